FILE: rtl/core/icmpv4_message_parser_top_defines.svh
// ----------------------------------------------------------------------------
// icmpv4_message_parser_top_defines.svh
// Assertion macros used by the ICMPv4 parser top level.
// ----------------------------------------------------------------------------
`ifndef ICMPV4_MESSAGE_PARSER_TOP_DEFINES_SVH
`define ICMPV4_MESSAGE_PARSER_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define ICMP4P_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, disabled while reset is asserted
`define ICMP4P_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

FILE: rtl/core/icmp4p_pkg.sv
// ----------------------------------------------------------------------------
// icmp4p_pkg
// Types, constants and helpers of the ICMPv4 message parser.
// ----------------------------------------------------------------------------
`default_nettype none

package icmp4p_pkg;

  localparam int HeaderBytes = 8;

  localparam logic [7:0] TypeEchoReply    = 8'd0;
  localparam logic [7:0] TypeDestUnreach  = 8'd3;
  localparam logic [7:0] TypeEcho         = 8'd8;
  localparam logic [7:0] TypeTimeExceeded = 8'd11;
  localparam logic [7:0] TypeParamProblem = 8'd12;
  localparam logic [7:0] CodeFragNeeded   = 8'd4;

  typedef enum logic [1:0] {
    KindNone   = 2'd0,
    KindEcho   = 2'd1,
    KindQuoted = 2'd2
  } payload_kind_e;

  // message state handed over at the last byte
  typedef struct packed {
    logic        is_short;
    logic [7:0]  msg_type;
    logic [7:0]  msg_code;
    logic [15:0] checksum_field;
    logic [31:0] rest_of_header;
    logic [15:0] body_length;
    logic        sum_ok;
  } msg_snap_t;

  typedef struct packed {
    logic          status;
    logic [7:0]    msg_type;
    logic [7:0]    msg_code;
    logic [15:0]   checksum_field;
    logic [15:0]   echo_id;
    logic [15:0]   echo_sequence;
    logic [15:0]   next_hop_mtu;
    payload_kind_e payload_kind;
    logic [15:0]   body_len;
    logic          sum_verified;
  } result_t;

  // ones'-complement add with end-around carry
  function automatic logic [15:0] ones_add(input logic [15:0] acc, input logic [15:0] word);
    logic [16:0] s;
    s = {1'b0, acc} + {1'b0, word};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/icmp4p_in_if.sv
// ----------------------------------------------------------------------------
// icmp4p_in_if
// Byte channel into the parser: valid/ready with byte and last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface icmp4p_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       is_last;

  modport source (output valid, output msg_byte, output is_last, input ready);
  modport sink   (input valid, input msg_byte, input is_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/icmp4p_out_if.sv
// ----------------------------------------------------------------------------
// icmp4p_out_if
// Result channel of the parser: valid/ready with the parsed header fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface icmp4p_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [7:0]  msg_type;
  logic [7:0]  msg_code;
  logic [15:0] checksum_field;
  logic [15:0] echo_id;
  logic [15:0] echo_sequence;
  logic [15:0] next_hop_mtu;
  logic [1:0]  payload_kind;
  logic [15:0] body_len;
  logic        sum_verified;

  modport source (
    output valid, output status, output msg_type, output msg_code,
    output checksum_field, output echo_id, output echo_sequence,
    output next_hop_mtu, output payload_kind, output body_len,
    output sum_verified, input ready
  );
  modport sink (
    input valid, input status, input msg_type, input msg_code,
    input checksum_field, input echo_id, input echo_sequence,
    input next_hop_mtu, input payload_kind, input body_len,
    input sum_verified, output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/icmp4p_track.sv
// ----------------------------------------------------------------------------
// icmp4p_track
// Per-message state: byte position, header capture and checksum sum.
// ----------------------------------------------------------------------------
`default_nettype none

module icmp4p_track
  import icmp4p_pkg::*;
#(
  parameter int MaxMessageBytes = 65535
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       fire_i,
  input  wire logic [7:0] msg_byte_i,
  input  wire logic       is_last_i,
  output msg_snap_t       snap_o
);

  localparam int CntW = $clog2(MaxMessageBytes + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [15:0]     sum_q, sum_d, sum_add, word;
  logic [7:0]      high_q, high_d;
  logic            pair_q, pair_d;
  logic [7:0]      type_q, type_d;
  logic [7:0]      code_q, code_d;
  logic [15:0]     csum_q, csum_d;
  logic [31:0]     roh_q, roh_d;

  always_comb begin
    type_d = type_q;
    code_d = code_q;
    csum_d = csum_q;
    roh_d  = roh_q;
    if (cnt_q == '0) begin
      type_d = msg_byte_i;
    end else if (cnt_q == CntW'(1)) begin
      code_d = msg_byte_i;
    end else if (cnt_q == CntW'(2) || cnt_q == CntW'(3)) begin
      csum_d = {csum_q[7:0], msg_byte_i};
    end else if (cnt_q < CntW'(HeaderBytes)) begin
      roh_d = {roh_q[23:0], msg_byte_i};
    end

    // unpaired byte at the end is padded with a zero low byte
    word    = pair_q ? {high_q, msg_byte_i} : {msg_byte_i, 8'h00};
    sum_add = ones_add(sum_q, word);
    if (pair_q) begin
      sum_d  = sum_add;
      high_d = high_q;
      pair_d = 1'b0;
    end else begin
      sum_d  = sum_q;
      high_d = msg_byte_i;
      pair_d = 1'b1;
    end

    cnt_d = (cnt_q != CntW'(MaxMessageBytes)) ? cnt_q + CntW'(1) : cnt_q;

    snap_o.is_short       = cnt_d < CntW'(HeaderBytes);
    snap_o.msg_type       = type_d;
    snap_o.msg_code       = code_d;
    snap_o.checksum_field = csum_d;
    snap_o.rest_of_header = roh_d;
    snap_o.body_length    = 16'(cnt_d) - 16'(HeaderBytes);
    snap_o.sum_ok         = sum_add == 16'hFFFF;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sum_q  <= '0;
      high_q <= '0;
      pair_q <= 1'b0;
      type_q <= '0;
      code_q <= '0;
      csum_q <= '0;
      roh_q  <= '0;
    end else if (fire_i) begin
      if (is_last_i) begin
        cnt_q  <= '0;
        sum_q  <= '0;
        high_q <= '0;
        pair_q <= 1'b0;
        type_q <= '0;
        code_q <= '0;
        csum_q <= '0;
        roh_q  <= '0;
      end else begin
        cnt_q  <= cnt_d;
        sum_q  <= sum_d;
        high_q <= high_d;
        pair_q <= pair_d;
        type_q <= type_d;
        code_q <= code_d;
        csum_q <= csum_d;
        roh_q  <= roh_d;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/icmp4p_result.sv
// ----------------------------------------------------------------------------
// icmp4p_result
// Decodes the message type and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module icmp4p_result
  import icmp4p_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      snap_valid_i,
  input  wire msg_snap_t snap_i,
  output logic           free_o,
  icmp4p_out_if.source   out_o
);

  result_t res_d, res_q;
  logic    valid_q;

  always_comb begin
    res_d = '0;
    if (snap_i.is_short) begin
      res_d.status = 1'b1;
    end else begin
      res_d.msg_type       = snap_i.msg_type;
      res_d.msg_code       = snap_i.msg_code;
      res_d.checksum_field = snap_i.checksum_field;
      res_d.sum_verified   = snap_i.sum_ok;
      case (snap_i.msg_type) inside
        TypeEchoReply, TypeEcho: begin
          res_d.echo_id       = snap_i.rest_of_header[31:16];
          res_d.echo_sequence = snap_i.rest_of_header[15:0];
          res_d.payload_kind  = KindEcho;
        end
        TypeDestUnreach: begin
          if (snap_i.msg_code == CodeFragNeeded) begin
            res_d.next_hop_mtu = snap_i.rest_of_header[15:0];
          end
          res_d.payload_kind = KindQuoted;
        end
        TypeTimeExceeded, TypeParamProblem: begin
          res_d.payload_kind = KindQuoted;
        end
        default: begin
          res_d.payload_kind = KindNone;
        end
      endcase
      if (res_d.payload_kind != KindNone) begin
        res_d.body_len = snap_i.body_length;
      end
    end
  end

  assign free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= snap_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && snap_valid_i) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = valid_q;
  assign out_o.status         = res_q.status;
  assign out_o.msg_type       = res_q.msg_type;
  assign out_o.msg_code       = res_q.msg_code;
  assign out_o.checksum_field = res_q.checksum_field;
  assign out_o.echo_id        = res_q.echo_id;
  assign out_o.echo_sequence  = res_q.echo_sequence;
  assign out_o.next_hop_mtu   = res_q.next_hop_mtu;
  assign out_o.payload_kind   = res_q.payload_kind;
  assign out_o.body_len       = res_q.body_len;
  assign out_o.sum_verified   = res_q.sum_verified;

endmodule

`default_nettype wire

FILE: rtl/core/icmpv4_message_parser_top.sv
// ----------------------------------------------------------------------------
// icmpv4_message_parser_top
// ICMPv4 header parser with Internet checksum check, one byte per transfer.
// ----------------------------------------------------------------------------
// Takes one message byte per cycle unless a last byte waits for a free
// result register, and gives one result per message. The byte flagged last
// passes the input register, then loads the result register once it is free.
// The byte path is an input register, one 16-bit ones'-complement add with
// header capture, and the result register; that single adder sets the rate
// of one byte per cycle outside such stalls. A waiting result does not stop
// the byte stream until a second last byte arrives behind it. Messages under
// 8 bytes report status 1; the byte count saturates at MaxMessageBytes.
`default_nettype none

`include "icmpv4_message_parser_top_defines.svh"

module icmpv4_message_parser_top
  import icmp4p_pkg::*;
#(
  parameter int MaxMessageBytes = 65535
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  icmp4p_in_if.sink    in_i,
  icmp4p_out_if.source out_o
);

  logic       s1_valid_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       s1_go;
  logic       res_free;
  msg_snap_t  snap;

  assign s1_go      = s1_valid_q && (!last_q || res_free);
  assign in_i.ready = !s1_valid_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      byte_q <= in_i.msg_byte;
      last_q <= in_i.is_last;
    end
  end

  icmp4p_track #(
    .MaxMessageBytes(MaxMessageBytes)
  ) u_track (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (s1_go),
    .msg_byte_i (byte_q),
    .is_last_i  (last_q),
    .snap_o     (snap)
  );

  icmp4p_result u_result (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (s1_go && last_q),
    .snap_i       (snap),
    .free_o       (res_free),
    .out_o        (out_o)
  );

  `ICMP4P_ASSERT_SAME(a_short_clear, clk_i, rst_ni,
    out_o.valid && out_o.status,
    out_o.msg_type == 8'd0 && out_o.payload_kind == KindNone && !out_o.sum_verified)

  `ICMP4P_ASSERT_SAME(a_len_needs_kind, clk_i, rst_ni,
    out_o.valid && out_o.payload_kind == KindNone, out_o.body_len == 16'd0)

  `ICMP4P_ASSERT_SAME(a_mtu_unreach, clk_i, rst_ni,
    out_o.valid && out_o.next_hop_mtu != 16'd0, out_o.msg_type == TypeDestUnreach)

  `ICMP4P_ASSERT_NEXT(a_last_gives_result, clk_i, rst_ni,
    s1_valid_q && last_q && res_free, out_o.valid)

endmodule

`default_nettype wire

FILE: tb/sv/icmpv4_message_parser_top_test.sv
// ----------------------------------------------------------------------------
// icmpv4_message_parser_top_test
// Self-checking bench for the ICMPv4 header parser: feeds byte streams,
// predicts each parsed header and checksum verdict, and compares every
// result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module icmpv4_message_parser_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import icmp4p_pkg::*;

  localparam logic [15:0] CountMax    = 16'hFFFF;
  localparam int unsigned StallLimit  = 3000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned ReportMax   = 10;
  localparam int unsigned HoldCycles  = 300;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  icmp4p_in_if  byte_ch ();
  icmp4p_out_if hdr_ch ();

  icmpv4_message_parser_top u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (byte_ch),
    .out_o (hdr_ch)
  );

  always #5ns clk_i = ~clk_i;

  // running parse of the message in flight
  logic [15:0] msg_len;
  logic [15:0] run_sum;
  logic [7:0]  hi_byte;
  logic        hi_pending;
  logic [7:0]  hdr_type;
  logic [7:0]  hdr_code;
  logic [15:0] hdr_csum;
  logic [31:0] hdr_rest;

  result_t     parsed_hdr_q[$];
  logic [7:0]  msg_buf[$];

  logic        src_gaps_on;
  logic        sink_gaps_on;
  int unsigned hold_len = 0;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned fail_cnt = 0;
  int unsigned report_cnt = 0;

  function automatic logic [15:0] csum_add(input logic [15:0] acc, input logic [15:0] word);
    logic [31:0] t;
    t = 32'(acc) + 32'(word);
    return t[15:0] + t[31:16];
  endfunction

  function automatic void clear_parse();
    msg_len    = '0;
    run_sum    = '0;
    hi_byte    = '0;
    hi_pending = 1'b0;
    hdr_type   = '0;
    hdr_code   = '0;
    hdr_csum   = '0;
    hdr_rest   = '0;
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic last);
    result_t hdr;
    if (msg_len == 16'd0) hdr_type = b;
    else if (msg_len == 16'd1) hdr_code = b;
    else if (msg_len < 16'd4) hdr_csum = {hdr_csum[7:0], b};
    else if (msg_len < HeaderBytes) hdr_rest = {hdr_rest[23:0], b};

    if (hi_pending) run_sum = csum_add(run_sum, {hi_byte, b});
    else hi_byte = b;
    hi_pending = ~hi_pending;

    if (msg_len != CountMax) msg_len++;
    if (!last) return;

    // odd length: pad the final high byte with zero
    if (hi_pending) run_sum = csum_add(run_sum, {hi_byte, 8'h00});

    hdr = '0;
    if (msg_len < HeaderBytes) begin
      hdr.status = 1'b1;
    end else begin
      hdr.msg_type       = hdr_type;
      hdr.msg_code       = hdr_code;
      hdr.checksum_field = hdr_csum;
      hdr.payload_kind   = KindNone;
      if (hdr_type == TypeEchoReply || hdr_type == TypeEcho) begin
        hdr.echo_id       = hdr_rest[31:16];
        hdr.echo_sequence = hdr_rest[15:0];
        hdr.payload_kind  = KindEcho;
      end else if (hdr_type == TypeDestUnreach) begin
        if (hdr_code == CodeFragNeeded) hdr.next_hop_mtu = hdr_rest[15:0];
        hdr.payload_kind = KindQuoted;
      end else if (hdr_type == TypeTimeExceeded || hdr_type == TypeParamProblem) begin
        hdr.payload_kind = KindQuoted;
      end
      if (hdr.payload_kind != KindNone) hdr.body_len = msg_len - 16'(HeaderBytes);
      hdr.sum_verified = (run_sum == 16'hFFFF);
    end
    parsed_hdr_q.push_back(hdr);
    clear_parse();
  endfunction

  function automatic void fill_msg(input logic [7:0] val, input int unsigned len);
    msg_buf.delete();
    repeat (len) msg_buf.push_back(val);
  endfunction

  function automatic void build_msg(input logic [7:0] mtype, input logic [7:0] mcode,
                                    input int unsigned len, input bit good_csum);
    logic [15:0] s;
    msg_buf.delete();
    repeat (len) msg_buf.push_back(8'($urandom));
    if (len > 0) msg_buf[0] = mtype;
    if (len > 1) msg_buf[1] = mcode;
    if (good_csum && len >= HeaderBytes) begin
      msg_buf[2] = 8'h00;
      msg_buf[3] = 8'h00;
      s = '0;
      for (int i = 0; i < len; i += 2) begin
        s = csum_add(s, {msg_buf[i], (i + 1 < len) ? msg_buf[i + 1] : 8'h00});
      end
      s = ~s;
      msg_buf[2] = s[15:8];
      msg_buf[3] = s[7:0];
    end
  endfunction

  // called at a rising edge, returns at the rising edge of the transfer
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (src_gaps_on && $urandom_range(99) < 13) begin
      byte_ch.valid    <= 1'b0;
      byte_ch.msg_byte <= 8'($urandom);
      byte_ch.is_last  <= 1'($urandom);
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    byte_ch.valid    <= 1'b1;
    byte_ch.msg_byte <= b;
    byte_ch.is_last  <= last;
    do @(negedge clk_i); while (!byte_ch.ready);
    parse_byte(b, last);
    @(posedge clk_i);
  endtask

  task automatic send_msg();
    foreach (msg_buf[i]) send_byte(msg_buf[i], i == msg_buf.size() - 1);
  endtask

  task automatic send_random_msg(output int unsigned n);
    logic [7:0]  mtype;
    logic [7:0]  mcode;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 12) n = $urandom_range(7, 1);
    else if (pick < 85) n = $urandom_range(24, 8);
    else n = $urandom_range(64, 25);
    case ($urandom_range(6))
      0: mtype = TypeEchoReply;
      1: mtype = TypeEcho;
      2: mtype = TypeDestUnreach;
      3: mtype = TypeTimeExceeded;
      4: mtype = TypeParamProblem;
      default: mtype = 8'($urandom);
    endcase
    if (mtype == TypeDestUnreach && $urandom_range(1) == 1) mcode = CodeFragNeeded;
    else mcode = 8'($urandom);
    build_msg(mtype, mcode, n, $urandom_range(99) < 70);
    send_msg();
  endtask

  task automatic run_random(input int unsigned byte_budget);
    int unsigned sent;
    int unsigned n;
    sent = 0;
    while (sent < byte_budget) begin
      send_random_msg(n);
      sent += n;
    end
  endtask

  task automatic test_directed();
    fill_msg(8'h00, 1);                          // single byte
    send_msg();
    fill_msg(8'hFF, 7);                          // one short of a header
    send_msg();
    fill_msg(8'h00, 8);                          // echo reply, all zero: sum fails
    send_msg();
    fill_msg(8'hFF, 8);                          // unknown type, all ones
    send_msg();
    build_msg(TypeEcho, 8'h00, 8, 1'b1);
    send_msg();
    build_msg(TypeEchoReply, 8'h00, 9, 1'b1);    // odd length
    send_msg();
    build_msg(TypeDestUnreach, CodeFragNeeded, 12, 1'b1);
    send_msg();
    build_msg(TypeDestUnreach, 8'h00, 11, 1'b0);
    send_msg();
    build_msg(TypeTimeExceeded, 8'h01, 8, 1'b1);
    send_msg();
    build_msg(TypeParamProblem, 8'h00, 10, 1'b1);
    send_msg();
    fill_msg(8'hFF, 9);                          // max MTU
    msg_buf[0] = TypeDestUnreach;
    msg_buf[1] = CodeFragNeeded;
    send_msg();
    build_msg(8'd5, 8'h00, 8, 1'b1);
    send_msg();
  endtask

  task automatic test_random_steady();
    src_gaps_on  = 1'b0;
    sink_gaps_on <= 1'b0;
    run_random(200);
  endtask

  task automatic test_random_gaps();
    src_gaps_on  = 1'b1;
    sink_gaps_on <= 1'b1;
    run_random(300);
  endtask

  task automatic test_output_hold();
    hold_len <= HoldCycles;
    hold_req <= hold_req + 1;
    run_random(100);
  endtask

  task automatic test_long_message();
    src_gaps_on  = 1'b0;
    sink_gaps_on <= 1'b0;
    // long echo payload, then a short header right behind it
    build_msg(TypeEcho, 8'h00, 200, 1'b1);
    send_msg();
    build_msg(TypeDestUnreach, CodeFragNeeded, 8, 1'b1);
    send_msg();
  endtask

  // result side: ready pattern and long hold-off requested by a test
  initial begin : sink_proc
    int unsigned hold_left;
    hold_left = 0;
    hdr_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = hold_len;
      end
      if (hold_left != 0) begin
        hold_left--;
        hdr_ch.ready <= 1'b0;
      end else begin
        hdr_ch.ready <= !(sink_gaps_on && $urandom_range(99) < 25);
      end
    end
  end

  function automatic void check_hdr();
    result_t got;
    result_t want;
    got.status         = hdr_ch.status;
    got.msg_type       = hdr_ch.msg_type;
    got.msg_code       = hdr_ch.msg_code;
    got.checksum_field = hdr_ch.checksum_field;
    got.echo_id        = hdr_ch.echo_id;
    got.echo_sequence  = hdr_ch.echo_sequence;
    got.next_hop_mtu   = hdr_ch.next_hop_mtu;
    got.payload_kind   = payload_kind_e'(hdr_ch.payload_kind);
    got.body_len       = hdr_ch.body_len;
    got.sum_verified   = hdr_ch.sum_verified;
    if (parsed_hdr_q.size() == 0) begin
      fail_cnt++;
      report_cnt++;
      if (report_cnt <= ReportMax)
        $display("%0t: result with no message pending, type %02h", $realtime, got.msg_type);
      return;
    end
    want = parsed_hdr_q.pop_front();
    if (got !== want) begin
      fail_cnt++;
      report_cnt++;
      if (report_cnt <= ReportMax) begin
        $display("%0t: header mismatch", $realtime);
        $display("  exp st=%0d ty=%02h cd=%02h ck=%04h id=%04h sq=%04h mtu=%04h kd=%0d len=%0d ok=%0d",
                 want.status, want.msg_type, want.msg_code, want.checksum_field, want.echo_id,
                 want.echo_sequence, want.next_hop_mtu, want.payload_kind,
                 want.body_len, want.sum_verified);
        $display("  got st=%0d ty=%02h cd=%02h ck=%04h id=%04h sq=%04h mtu=%04h kd=%0d len=%0d ok=%0d",
                 got.status, got.msg_type, got.msg_code, got.checksum_field, got.echo_id,
                 got.echo_sequence, got.next_hop_mtu, got.payload_kind,
                 got.body_len, got.sum_verified);
      end
    end
  endfunction

  // sampled mid-cycle: a transfer seen here completes at the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni && hdr_ch.valid && hdr_ch.ready) check_hdr();
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(negedge clk_i);
      if ((byte_ch.valid && byte_ch.ready) || (hdr_ch.valid && hdr_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("icmpv4_message_parser_top_test: FAIL");
    $finish;
  end

  initial begin
    byte_ch.valid    = 1'b0;
    byte_ch.msg_byte = 8'h00;
    byte_ch.is_last  = 1'b0;
    src_gaps_on      = 1'b1;
    sink_gaps_on     = 1'b1;
    clear_parse();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_steady();
    test_random_gaps();
    test_output_hold();
    test_long_message();

    byte_ch.valid <= 1'b0;
    while (parsed_hdr_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("icmpv4_message_parser_top_test: PASS");
    end else begin
      $display("icmpv4_message_parser_top_test: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/icmp4p_pkg.sv
rtl/core/icmp4p_in_if.sv
rtl/core/icmp4p_out_if.sv
rtl/core/icmp4p_track.sv
rtl/core/icmp4p_result.sv
rtl/core/icmpv4_message_parser_top.sv
tb/sv/icmpv4_message_parser_top_test.sv
